/* rtl/core/spq_pkg.sv */
// Package for the sorted priority queue: sizes, entry type, op and status codes.
// No dependencies; used by spq_cell and sorted_priority_queue.
package spq_pkg;

  localparam int DEPTH      = 16;
  localparam int ID_WIDTH   = 16;
  localparam int PRIO_WIDTH = 8;
  localparam int CNT_W      = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_SEARCH = 2'd2,
    MODE_NOP    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef struct packed {
    logic [ID_WIDTH-1:0]   id;
    logic [PRIO_WIDTH-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic   ins;
    logic   rem;
    entry_t item;
  } cell_ctl_t;

endpackage

/* rtl/core/spq_cell.sv */
// One queue slot: holds an entry, compares it against the incoming beat and
// shifts toward its neighbors. Depends on spq_pkg.
module spq_cell (
  input  logic               clk,
  input  spq_pkg::cell_ctl_t ctl,
  input  logic               slot_valid,
  input  logic               left_ge,
  input  spq_pkg::entry_t    left_entry,
  input  spq_pkg::entry_t    right_entry,
  output spq_pkg::entry_t    entry,
  output logic               ge,
  output logic               match
);
  import spq_pkg::*;

  entry_t entry_r;
  entry_t entry_nxt;

  assign entry = entry_r;
  assign ge    = slot_valid && (entry_r.prio >= ctl.item.prio);
  assign match = slot_valid && (entry_r.id == ctl.item.id);

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.ins && !ge) begin
      entry_nxt = left_ge ? ctl.item : left_entry;
    end else if (ctl.rem) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

/* rtl/core/sorted_priority_queue.sv */
// Top level of the sorted priority queue: stream ports, occupancy count,
// chain of spq_cell slots and the registered result. Depends on spq_pkg, spq_cell.
//
// Usage:
//   Each input beat carries one operation: add a job (id, priority), remove the
//   highest-priority job, or search for a job id. Every input beat yields
//   exactly one result beat with a status, a job id and a priority.
//   Entries are kept in descending priority order; equal priorities leave in
//   arrival order. An add to a full queue is dropped and reported.
//   The result beat appears in the cycle after the input beat is taken.
//   Throughput: one operation per cycle while the output is not stalled; every
//   slot of the cell chain compares and shifts in the same cycle, and the search
//   resolves the first matching slot in that cycle.
//   The result sits in an output register; a new input beat is taken whenever
//   that register is empty or is being drained in the same cycle, so a
//   stalled receiver holds back the input side only while the result waits.
//   Reset empties the queue (occupancy zero) and clears the result valid;
//   slot contents are not cleared and are never read before being written.
module sorted_priority_queue (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [1:0] mode, [17:2] job_id, [25:18] priority_req
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [1:0] status, [17:2] out_job_id, [25:18] out_priority
);
  import spq_pkg::*;

  mode_t                 mode;
  cell_ctl_t             ctl;
  logic                  in_fire;
  logic                  full;
  logic                  empty;
  logic [CNT_W-1:0]      occ_r;
  logic [CNT_W-1:0]      occ_nxt;

  entry_t                entries [DEPTH];
  logic   [DEPTH-1:0]    ge_vec;
  logic   [DEPTH-1:0]    match_vec;
  logic   [DEPTH-1:0]    first_hit;
  logic [PRIO_WIDTH-1:0] hit_prio;

  logic                  out_valid_r;
  status_t               status_r;
  status_t               status_nxt;
  logic [ID_WIDTH-1:0]   id_r;
  logic [ID_WIDTH-1:0]   id_nxt;
  logic [PRIO_WIDTH-1:0] prio_r;
  logic [PRIO_WIDTH-1:0] prio_nxt;

  assign mode      = mode_t'(in_tdata[1:0]);
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign full      = (occ_r == CNT_W'(DEPTH));
  assign empty     = (occ_r == '0);

  assign ctl.item.id   = in_tdata[2 +: ID_WIDTH];
  assign ctl.item.prio = in_tdata[2 + ID_WIDTH +: PRIO_WIDTH];
  assign ctl.ins       = in_fire && (mode == MODE_ADD) && !full;
  assign ctl.rem       = in_fire && (mode == MODE_REMOVE) && !empty;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
    spq_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .slot_valid  (occ_r > IDX),
      .left_ge     ((i == 0) ? 1'b1 : ge_vec[(i == 0) ? 0 : i - 1]),
      .left_entry  (entries[(i == 0) ? 0 : i - 1]),
      .right_entry (entries[(i == DEPTH - 1) ? i : i + 1]),
      .entry       (entries[i]),
      .ge          (ge_vec[i]),
      .match       (match_vec[i])
    );
  end

  assign first_hit = match_vec & ~(match_vec - DEPTH'(1));

  always_comb begin
    hit_prio = '0;
    for (int k = 0; k < DEPTH; k++) begin
      hit_prio = hit_prio | (first_hit[k] ? entries[k].prio : '0);
    end
  end

  always_comb begin
    occ_nxt = occ_r;
    if (ctl.ins) begin
      occ_nxt = occ_r + CNT_W'(1);
    end else if (ctl.rem) begin
      occ_nxt = occ_r - CNT_W'(1);
    end
  end

  always_comb begin
    status_nxt = ST_OK;
    id_nxt     = '0;
    prio_nxt   = '0;
    unique case (mode)
      MODE_ADD: begin
        if (full) status_nxt = ST_FULL;
      end
      MODE_REMOVE: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          id_nxt   = entries[0].id;
          prio_nxt = entries[0].prio;
        end
      end
      MODE_SEARCH: begin
        id_nxt = ctl.item.id;
        if (|match_vec) begin
          prio_nxt = hit_prio;
        end else begin
          status_nxt = ST_NOTFOUND;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      status_r <= status_nxt;
      id_r     <= id_nxt;
      prio_r   <= prio_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, prio_r, id_r, status_r};

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CNT_W'(DEPTH))
    else $error("occupancy above depth");

  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && mode == MODE_ADD && full) |=>
      (out_valid_r && status_r == ST_FULL && occ_r == $past(occ_r)))
    else $error("add to full queue not dropped");

  a_rem_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && mode == MODE_REMOVE && !empty) |=>
      (occ_r == $past(occ_r) - CNT_W'(1) && status_r == ST_OK))
    else $error("remove did not shrink queue");

  a_search_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && mode == MODE_SEARCH) |=> $stable(occ_r))
    else $error("search changed occupancy");

endmodule

/* verif/spq_monitor.sv */
// Checker for the sorted priority queue: watches both stream channels, keeps a
// shadow copy of the queue and compares every result beat. Depends on spq_pkg.
module spq_monitor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,   // [1:0] mode, [17:2] job_id, [25:18] priority_req
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,  // [1:0] status, [17:2] out_job_id, [25:18] out_priority
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import spq_pkg::*;

  typedef struct packed {
    status_t               status;
    logic [ID_WIDTH-1:0]   job_id;
    logic [PRIO_WIDTH-1:0] prio;
  } reply_t;

  entry_t shadow_slots [DEPTH];
  int     shadow_fill = 0;
  reply_t awaited_replies [$];
  int     mismatches = 0;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic reply_t apply_queue_op(input mode_t op,
                                            input logic [ID_WIDTH-1:0] id,
                                            input logic [PRIO_WIDTH-1:0] prio);
    reply_t r;
    int     pos;
    int     k;
    r.status = ST_OK;
    r.job_id = '0;
    r.prio   = '0;
    case (op)
      MODE_ADD: begin
        if (shadow_fill >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          pos = 0;
          while (pos < shadow_fill && shadow_slots[pos].prio >= prio) pos++;
          for (k = shadow_fill; k > pos; k--) shadow_slots[k] = shadow_slots[k-1];
          shadow_slots[pos].id   = id;
          shadow_slots[pos].prio = prio;
          shadow_fill++;
        end
      end
      MODE_REMOVE: begin
        if (shadow_fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.job_id = shadow_slots[0].id;
          r.prio   = shadow_slots[0].prio;
          for (k = 1; k < shadow_fill; k++) shadow_slots[k-1] = shadow_slots[k];
          shadow_fill--;
        end
      end
      MODE_SEARCH: begin
        r.status = ST_NOTFOUND;
        r.job_id = id;
        // scan from the back so the front-most match wins
        for (k = shadow_fill - 1; k >= 0; k--) begin
          if (shadow_slots[k].id == id) begin
            r.status = ST_OK;
            r.prio   = shadow_slots[k].prio;
          end
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    reply_t want;
    reply_t got;
    if (!rst_n) begin
      shadow_fill = 0;
      awaited_replies.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got.status = status_t'(out_tdata[1:0]);
        got.job_id = out_tdata[17:2];
        got.prio   = out_tdata[25:18];
        if (awaited_replies.size() == 0) begin
          $display("%0t: unexpected result beat: status %0d id %h prio %h",
                   $time, got.status, got.job_id, got.prio);
          mismatches++;
        end else begin
          want = awaited_replies.pop_front();
          if (got.status != want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            mismatches++;
          end
          if (got.job_id != want.job_id) begin
            $display("%0t: job_id expected %h actual %h", $time, want.job_id, got.job_id);
            mismatches++;
          end
          if (got.prio != want.prio) begin
            $display("%0t: priority expected %h actual %h", $time, want.prio, got.prio);
            mismatches++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        awaited_replies.push_back(apply_queue_op(mode_t'(in_tdata[1:0]), in_tdata[17:2],
                                                 in_tdata[25:18]));
      end
    end
    pending    <= awaited_replies.size();
    fail_count <= mismatches;
  end

endmodule

/* verif/sorted_priority_queue_tb.sv */
// Testbench top for the sorted priority queue: clock, reset, operation stimulus
// and receiver stalls, verdict. Depends on spq_pkg, sorted_priority_queue, spq_monitor.
module sorted_priority_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import spq_pkg::*;

  localparam int RUN_LIMIT     = 200000;
  localparam int OPS_PER_PHASE = 320;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  int          fail_count;
  int          pending;
  int          gap_pct    = 0;
  int          stall_pct  = 0;
  int unsigned cycle_cnt  = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sorted_priority_queue i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  spq_monitor i_monitor (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == RUN_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_op(input mode_t op, input logic [ID_WIDTH-1:0] id,
                         input logic [PRIO_WIDTH-1:0] prio);
    if ($urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'd0, prio, id, op};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic wait_for_replies;
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    int                    ph;
    int                    n;
    int unsigned           r;
    int unsigned           add_bias;
    mode_t                 op;
    logic [ID_WIDTH-1:0]   id;
    logic [PRIO_WIDTH-1:0] prio;

    add_bias = 50;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty queue, unused mode, ties, duplicate ids, field extremes
    send_op(MODE_REMOVE, 16'hFFFF, 8'hFF);
    send_op(MODE_SEARCH, 16'h0000, 8'h00);
    send_op(MODE_NOP,    16'hA5C3, 8'h5A);
    send_op(MODE_ADD,    16'hFFFF, 8'hFF);
    send_op(MODE_ADD,    16'h0000, 8'h00);
    send_op(MODE_ADD,    16'h0001, 8'hFF);
    send_op(MODE_ADD,    16'h0002, 8'h80);
    send_op(MODE_ADD,    16'h0003, 8'h80);
    send_op(MODE_ADD,    16'h0002, 8'h7F);
    send_op(MODE_SEARCH, 16'hFFFF, 8'h00);
    send_op(MODE_SEARCH, 16'h0000, 8'hFF);
    send_op(MODE_SEARCH, 16'h0002, 8'h00);
    send_op(MODE_SEARCH, 16'h1234, 8'h00);
    send_op(MODE_NOP,    16'h5A3C, 8'hA5);
    repeat (7) send_op(MODE_REMOVE, 16'h5555, 8'hAA);
    wait_for_replies();

    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          gap_pct = 20;
          stall_pct <= 65;
        end
        1: begin
          gap_pct = 65;
          stall_pct <= 20;
        end
        default: begin
          gap_pct = 0;
          stall_pct <= 0;
        end
      endcase
      for (n = 0; n < OPS_PER_PHASE; n++) begin
        // pick a filling or draining bias at random every 40 ops so full and empty both occur
        if (n % 40 == 0) add_bias = ($urandom_range(1) != 0) ? 75 : 30;
        r = $urandom_range(99);
        if (r < 3) op = MODE_NOP;
        else if (r < add_bias) op = MODE_ADD;
        else if ($urandom_range(1) != 0) op = MODE_REMOVE;
        else op = MODE_SEARCH;
        id   = ($urandom_range(3) != 0) ? ID_WIDTH'($urandom_range(15)) : ID_WIDTH'($urandom);
        prio = ($urandom_range(1) != 0) ? PRIO_WIDTH'($urandom_range(3))
                                        : PRIO_WIDTH'($urandom);
        send_op(op, id, prio);
      end
      wait_for_replies();
    end

    repeat (4) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
